// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL, included by trigger_fade_envelope.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hdl/tfe_pkg.sv =====
// Package for the trigger fade envelope: codes, reset values, divider status.
// No dependencies.
package tfe_pkg;

  localparam int ElapsedBitsDef  = 20;
  localparam int DurationBitsDef = 16;
  localparam int CfgDurBits      = 16;
  localparam int QuotBits        = 8;

  // register indexes
  localparam logic [2:0] CfgRangeEnable = 3'd0;
  localparam logic [2:0] CfgRangeLow    = 3'd1;
  localparam logic [2:0] CfgRangeHigh   = 3'd2;
  localparam logic [2:0] CfgFadeMs      = 3'd3;
  localparam logic [2:0] CfgHoldMs      = 3'd4;

  // register reset values
  localparam logic        RangeEnableRst = 1'b1;
  localparam logic [31:0] RangeLowRst    = 32'd66;
  localparam logic [31:0] RangeHighRst   = 32'd65536000;
  localparam logic [15:0] FadeMsRst      = 16'd200;
  localparam logic [15:0] HoldMsRst      = 16'd0;

  // item modes
  localparam logic [1:0] ModeTick    = 2'd0;
  localparam logic [1:0] ModeTrigger = 2'd1;
  localparam logic [1:0] ModeLevel   = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  // envelope phases
  localparam logic [1:0] PhOff = 2'd0;
  localparam logic [1:0] PhIn  = 2'd1;
  localparam logic [1:0] PhOn  = 2'd2;
  localparam logic [1:0] PhOut = 2'd3;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [QuotBits-1:0] quot;
  } div_stat_t;

endpackage

// ===== hdl/tfe_div.sv =====
// Serial ratio unit: min(255, e*255/f), one restoring step per cycle.
// Depends on tfe_pkg.
module tfe_div #(
  parameter int DIVIDEND_BITS = tfe_pkg::ElapsedBitsDef,
  parameter int DIVISOR_BITS  = tfe_pkg::DurationBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output tfe_pkg::div_stat_t       stat_o
);
  import tfe_pkg::*;

  localparam int NW = DIVIDEND_BITS + QuotBits;
  localparam int CntBits = $clog2(QuotBits);

  localparam logic [1:0] DIdle = 2'd0;
  localparam logic [1:0] DSat  = 2'd1;
  localparam logic [1:0] DStep = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [NW-1:0]       dsh_q, dsh_d;
  logic [QuotBits-1:0] quot_q, quot_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                done_q, done_d;
  logic                ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DIdle: begin
        if (start_i) begin
          // e*255 as (e << 8) - e
          rem_d   = {dividend_i, {QuotBits{1'b0}}} - NW'(dividend_i);
          dsh_d   = NW'({divisor_i, {QuotBits{1'b0}}});
          state_d = DSat;
        end
      end
      DSat: begin
        // zero fade or quotient past 255: saturate
        if (dsh_q == '0 || ge) begin
          quot_d  = '1;
          done_d  = 1'b1;
          state_d = DIdle;
        end else begin
          quot_d  = '0;
          dsh_d   = dsh_q >> 1;
          cnt_d   = CntBits'(QuotBits - 1);
          state_d = DStep;
        end
      end
      DStep: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quot_d = {quot_q[QuotBits-2:0], ge};
        dsh_d  = dsh_q >> 1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DIdle;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
  end

  assign stat_o.busy = state_q != DIdle;
  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule

// ===== hdl/trigger_fade_envelope.sv =====
// Activity indicator envelope (off, fade in, on, fade out) with 8-bit opacity.
// Depends on tfe_pkg, tfe_div and assert_macros.svh.
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid_i/in_ready_o, mode, elapsed, level, ok | in
//  result   | out_valid_o/out_ready_i, opacity, phase, timer  | out
//  config   | cfg_we_i, cfg_addr_i, cfg_wdata_i               | in
//
// Sequence: capture, update, phase check (skipped for the unused mode), ratio
//   start, ratio wait, output; ready returns as the result is loaded. The ratio
//   wait ends at its first compare when the ratio saturates, else after eight serial steps.
// Reset: envelope clears to off, timer stopped; registers take reset values.
// Stalls: the result register holds until taken; a finished item waits in the
//   output step while the previous result is still pending.
`include "assert_macros.svh"

module trigger_fade_envelope #(
  parameter int ELAPSED_BITS  = tfe_pkg::ElapsedBitsDef,
  parameter int DURATION_BITS = tfe_pkg::DurationBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         elapsed_ms_i,
  input  logic signed [31:0] level_value_i,
  input  logic               value_valid_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         opacity_o,
  output logic [1:0]         phase_o,
  output logic               timer_running_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);
  import tfe_pkg::*;

  // Elapsed time is kept wide enough for a reversed fade, which is not
  // clipped to the elapsed width.
  localparam int EW = (ELAPSED_BITS > DURATION_BITS) ? ELAPSED_BITS : DURATION_BITS;
  localparam int CW = (DURATION_BITS > CfgDurBits) ? DURATION_BITS : CfgDurBits;
  localparam logic [EW:0]   ElapsedMax = (EW + 1)'((64'd1 << ELAPSED_BITS) - 64'd1);
  localparam logic [CW-1:0] DurMax     = CW'((64'd1 << DURATION_BITS) - 64'd1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SUpd   = 3'd1;
  localparam logic [2:0] SChk   = 3'd2;
  localparam logic [2:0] SStart = 3'd3;
  localparam logic [2:0] SWait  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  // configuration
  logic               range_en_q;
  logic signed [31:0] range_low_q, range_high_q;
  logic [15:0]        fade_ms_q, hold_ms_q;

  // captured item
  logic [1:0]         mode_q;
  logic [9:0]         dt_q;
  logic signed [31:0] level_q;
  logic               vvalid_q;

  // sequencer and envelope state
  logic [2:0]               state_q, state_d;
  logic [1:0]               phase_q, phase_d;
  logic [EW-1:0]            elapsed_q, elapsed_d;
  logic [DURATION_BITS-1:0] fade_len_q, fade_len_d;
  logic [DURATION_BITS-1:0] hold_len_q, hold_len_d;
  logic                     hold_forever_q, hold_forever_d;
  logic                     running_q, running_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] opacity_q, opacity_d;
  logic [1:0] phase_out_q;
  logic       running_out_q;

  logic                     div_start;
  div_stat_t                div_st;

  // item decode and timing load
  logic [CW-1:0]            fade_ext, hold_ext;
  logic [DURATION_BITS-1:0] nf, nh, hold_sat;
  logic                     nfor, is_flash, timing_chg, in_range, turn_on;
  logic [EW-1:0]            nf_e, rev, tick_e;
  logic [EW:0]              tick_sum;
  logic                     e_ge_f, e_ge_h;

  always_comb begin
    fade_ext = CW'(fade_ms_q);
    hold_ext = CW'(hold_ms_q);
    nf       = (fade_ext > DurMax) ? DurMax[DURATION_BITS-1:0] : fade_ext[DURATION_BITS-1:0];
    hold_sat = (hold_ext > DurMax) ? DurMax[DURATION_BITS-1:0] : hold_ext[DURATION_BITS-1:0];
    is_flash = (mode_q == ModeTrigger) || (mode_q == ModeLevel && !range_en_q);
    nh       = is_flash ? hold_sat : '0;
    nfor     = !is_flash;
    timing_chg = (nf != fade_len_q) || (nh != hold_len_q) || (nfor != hold_forever_q);
    // reversed bounds swap
    if (range_low_q > range_high_q) begin
      in_range = level_q >= range_high_q && level_q <= range_low_q;
    end else begin
      in_range = level_q >= range_low_q && level_q <= range_high_q;
    end
    turn_on  = is_flash || (vvalid_q && in_range);
    nf_e     = EW'(nf);
    rev      = (elapsed_q < nf_e) ? nf_e - elapsed_q : '0;
    tick_sum = {1'b0, elapsed_q} + (EW + 1)'(dt_q);
    tick_e   = (tick_sum > ElapsedMax) ? ElapsedMax[EW-1:0] : tick_sum[EW-1:0];
    e_ge_f   = elapsed_q >= EW'(fade_len_q);
    e_ge_h   = elapsed_q >= EW'(hold_len_q);
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    elapsed_d      = elapsed_q;
    fade_len_d     = fade_len_q;
    hold_len_d     = hold_len_q;
    hold_forever_d = hold_forever_q;
    running_d      = running_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    opacity_d      = opacity_q;
    div_start      = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SUpd;
        end
      end
      SUpd: begin
        state_d = SChk;
        unique case (mode_q)
          ModeTick: begin
            if (running_q) begin
              elapsed_d = tick_e;
            end
          end
          ModeTrigger, ModeLevel: begin
            // load timing; a changed finite hold restarts a stopped timer
            fade_len_d     = nf;
            hold_len_d     = nh;
            hold_forever_d = nfor;
            if (timing_chg && phase_q == PhOn && !nfor) begin
              running_d = 1'b1;
            end
            if (turn_on) begin
              unique case (phase_q)
                PhOff: begin
                  elapsed_d = '0;
                  phase_d   = PhIn;
                  running_d = 1'b1;
                end
                PhOn:  elapsed_d = '0;
                PhOut: begin
                  elapsed_d = rev;
                  phase_d   = PhIn;
                end
                default: ;
              endcase
            end else begin
              unique case (phase_q)
                PhIn: begin
                  elapsed_d = rev;
                  phase_d   = PhOut;
                end
                PhOn: begin
                  elapsed_d = '0;
                  phase_d   = PhOut;
                  running_d = 1'b1;
                end
                default: ;
              endcase
            end
          end
          default: state_d = SStart;  // unused mode: no change, no check
        endcase
      end
      SChk: begin
        state_d = SStart;
        unique case (phase_q)
          PhIn: begin
            if (fade_len_q == '0 || e_ge_f) begin
              phase_d   = PhOn;
              elapsed_d = '0;
            end
          end
          PhOn: begin
            if (hold_forever_q) begin
              running_d = 1'b0;
            end else if (hold_len_q == '0 || e_ge_h) begin
              phase_d   = PhOut;
              elapsed_d = '0;
            end
          end
          PhOut: begin
            if (fade_len_q == '0 || e_ge_f) begin
              phase_d   = PhOff;
              running_d = 1'b0;
            end
          end
          default: running_d = 1'b0;
        endcase
      end
      SStart: begin
        div_start = 1'b1;
        state_d   = SWait;
      end
      SWait: begin
        if (div_st.done) begin
          state_d = SOut;
        end
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          unique case (phase_q)
            PhIn:    opacity_d = div_st.quot;
            PhOn:    opacity_d = 8'hFF;
            PhOut:   opacity_d = ~div_st.quot;
            default: opacity_d = 8'h00;
          endcase
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign in_ready_o = state_q == SIdle;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_en_q   <= RangeEnableRst;
      range_low_q  <= RangeLowRst;
      range_high_q <= RangeHighRst;
      fade_ms_q    <= FadeMsRst;
      hold_ms_q    <= HoldMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgRangeEnable: range_en_q   <= cfg_wdata_i[0];
        CfgRangeLow:    range_low_q  <= cfg_wdata_i;
        CfgRangeHigh:   range_high_q <= cfg_wdata_i;
        CfgFadeMs:      fade_ms_q    <= cfg_wdata_i[15:0];
        CfgHoldMs:      hold_ms_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      phase_q        <= PhOff;
      elapsed_q      <= '0;
      fade_len_q     <= '0;
      hold_len_q     <= '0;
      hold_forever_q <= 1'b0;
      running_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      elapsed_q      <= elapsed_d;
      fade_len_q     <= fade_len_d;
      hold_len_q     <= hold_len_d;
      hold_forever_q <= hold_forever_d;
      running_q      <= running_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      dt_q     <= elapsed_ms_i;
      level_q  <= level_value_i;
      vvalid_q <= value_valid_i;
    end
    opacity_q <= opacity_d;
    if (state_q == SOut && (!out_valid_q || out_ready_i)) begin
      phase_out_q   <= phase_q;
      running_out_q <= running_q;
    end
  end

  tfe_div #(
    .DIVIDEND_BITS(EW),
    .DIVISOR_BITS (DURATION_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(elapsed_q),
    .divisor_i (fade_len_q),
    .stat_o    (div_st)
  );

  assign out_valid_o     = out_valid_q;
  assign opacity_o       = opacity_q;
  assign phase_o         = phase_out_q;
  assign timer_running_o = running_out_q;

  // an accepted item blocks the next one
  `ASSERT_PROP(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // the timer never runs while the envelope is off
  `ASSERT_NEVER(a_off_stopped, clk_i, rst_ni, phase_q == PhOff && running_q)
  // an infinite hold always comes with a zero hold length
  `ASSERT_NEVER(a_forever_no_hold, clk_i, rst_ni, hold_forever_q && hold_len_q != '0)
  // the ratio unit only works for the item being finished
  `ASSERT_PROP(a_div_owned, clk_i, rst_ni, (state_q == SIdle) |-> !div_st.busy)

endmodule

// ===== bench/tfe_envelope_checker.sv =====
`timescale 1ns / 1ps
// Checker for the trigger fade envelope: tracks register writes, predicts each result item
// and compares the result channel against it. Depends on tfe_pkg.
module tfe_envelope_checker
  import tfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         elapsed_ms_i,
  input  logic signed [31:0] level_value_i,
  input  logic               value_valid_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [7:0]         opacity_o,
  input  logic [1:0]         phase_o,
  input  logic               timer_running_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [7:0] opacity;
    logic [1:0] phase;
    logic       timer;
  } env_status_t;

  localparam longint unsigned ElapsedMax  = (64'd1 << ElapsedBitsDef) - 1;
  localparam longint unsigned DurationMax = (64'd1 << DurationBitsDef) - 1;

  // register copy
  logic               cfg_range_en;
  logic signed [31:0] cfg_lo;
  logic signed [31:0] cfg_hi;
  logic [15:0]        cfg_fade;
  logic [15:0]        cfg_hold;

  // envelope copy
  logic [1:0]         env_phase;
  longint unsigned    env_elapsed;
  longint unsigned    env_fade;
  longint unsigned    env_hold;
  logic               env_forever;
  logic               env_running;

  env_status_t        due_status_q[$];

  function automatic longint unsigned fade_ratio(longint unsigned e, longint unsigned d);
    longint unsigned r;
    if (d == 0) return 255;
    r = (e * 255) / d;
    return (r > 255) ? 255 : r;
  endfunction

  // elapsed time at the mirrored point of the fade
  function automatic longint unsigned mirrored_elapsed();
    return (env_elapsed < env_fade) ? env_fade - env_elapsed : 0;
  endfunction

  function automatic void load_timing(logic flash);
    longint unsigned nf;
    longint unsigned nh;
    nf = (cfg_fade > DurationMax) ? DurationMax : cfg_fade;
    nh = !flash ? 0 : (cfg_hold > DurationMax) ? DurationMax : cfg_hold;
    if (nf != env_fade || nh != env_hold || (!flash) != env_forever) begin
      env_fade    = nf;
      env_hold    = nh;
      env_forever = !flash;
      // restart a stopped finite hold
      if (env_phase == PhOn && !env_forever && !env_running) env_running = 1'b1;
    end
  endfunction

  function automatic void steer(logic want_on);
    if (want_on) begin
      case (env_phase)
        PhOff: begin
          env_elapsed = 0;
          env_phase   = PhIn;
          env_running = 1'b1;
        end
        PhOn:  env_elapsed = 0;
        PhOut: begin
          env_elapsed = mirrored_elapsed();
          env_phase   = PhIn;
        end
        default: ;
      endcase
    end else begin
      case (env_phase)
        PhIn: begin
          env_elapsed = mirrored_elapsed();
          env_phase   = PhOut;
        end
        PhOn: begin
          env_elapsed = 0;
          env_phase   = PhOut;
          env_running = 1'b1;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic env_status_t advance_envelope(logic [1:0] mode, logic [9:0] dt,
                                                   logic signed [31:0] lvl, logic lvl_ok);
    env_status_t        s;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint unsigned    op;
    if (mode != ModeUnused) begin
      if (mode == ModeTick) begin
        if (env_running) begin
          env_elapsed = env_elapsed + dt;
          if (env_elapsed > ElapsedMax) env_elapsed = ElapsedMax;
        end
      end else if (mode == ModeTrigger || !cfg_range_en) begin
        load_timing(1'b1);
        steer(1'b1);
      end else begin
        if (cfg_lo > cfg_hi) begin
          lo = cfg_hi;
          hi = cfg_lo;
        end else begin
          lo = cfg_lo;
          hi = cfg_hi;
        end
        load_timing(1'b0);
        steer(lvl_ok && lvl >= lo && lvl <= hi);
      end
      // one phase transition per item
      case (env_phase)
        PhIn: begin
          if (env_fade == 0 || env_elapsed >= env_fade) begin
            env_phase   = PhOn;
            env_elapsed = 0;
          end
        end
        PhOn: begin
          if (env_forever) begin
            env_running = 1'b0;
          end else if (env_hold == 0 || env_elapsed >= env_hold) begin
            env_phase   = PhOut;
            env_elapsed = 0;
          end
        end
        PhOut: begin
          if (env_fade == 0 || env_elapsed >= env_fade) begin
            env_phase   = PhOff;
            env_running = 1'b0;
          end
        end
        default: env_running = 1'b0;
      endcase
    end
    case (env_phase)
      PhIn:    op = fade_ratio(env_elapsed, env_fade);
      PhOn:    op = 255;
      PhOut:   op = 255 - fade_ratio(env_elapsed, env_fade);
      default: op = 0;
    endcase
    s.opacity = op[7:0];
    s.phase   = env_phase;
    s.timer   = env_running;
    return s;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 40)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    env_status_t got;
    env_status_t want;
    if (!rst_ni) begin
      cfg_range_en = RangeEnableRst;
      cfg_lo       = RangeLowRst;
      cfg_hi       = RangeHighRst;
      cfg_fade     = FadeMsRst;
      cfg_hold     = HoldMsRst;
      env_phase    = PhOff;
      env_elapsed  = 0;
      env_fade     = 0;
      env_hold     = 0;
      env_forever  = 1'b0;
      env_running  = 1'b0;
      due_status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // compare first: a result leaving now belongs to an older item
      if (out_valid_o && out_ready_i) begin
        got = {opacity_o, phase_o, timer_running_o};
        if (due_status_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no item waiting: expected none, %s %0d phase %0d timer %0b",
                   $time, "actual opacity", got.opacity, got.phase, got.timer);
        end else begin
          want = due_status_q.pop_front();
          check_field("opacity", want.opacity, got.opacity);
          check_field("phase", 8'(want.phase), 8'(got.phase));
          check_field("timer_running", 8'(want.timer), 8'(got.timer));
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_o)
        due_status_q.push_back(advance_envelope(mode_i, elapsed_ms_i, level_value_i,
                                                value_valid_i));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgRangeEnable: cfg_range_en = cfg_wdata_i[0];
          CfgRangeLow:    cfg_lo       = cfg_wdata_i;
          CfgRangeHigh:   cfg_hi       = cfg_wdata_i;
          CfgFadeMs:      cfg_fade     = cfg_wdata_i[15:0];
          CfgHoldMs:      cfg_hold     = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      pending_o = due_status_q.size();
    end
  end

endmodule

// ===== bench/tb_trigger_fade_envelope.sv =====
`timescale 1ns / 1ps
// Testbench top for the trigger fade envelope: clock, reset, stimulus and verdict.
// Depends on tfe_pkg, trigger_fade_envelope and tfe_envelope_checker.
module tb_trigger_fade_envelope;
  import tfe_pkg::*;

  localparam int ClkHalf      = 4;
  localparam int StallLimit   = 1000;  // cycles with no handshake on either channel
  localparam int Phases       = 7;
  localparam int PhaseItems   = 125;
  localparam int SettleCycles = 20;    // wait for stray results after the last drain

  localparam logic [31:0] QOne = 32'h0001_0000;  // 1.0 in Q16.16

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [1:0]         mode_i        = ModeTick;
  logic [9:0]         elapsed_ms_i  = '0;
  logic signed [31:0] level_value_i = '0;
  logic               value_valid_i = 1'b0;
  logic               out_ready_i   = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [2:0]         cfg_addr_i    = CfgRangeEnable;
  logic [31:0]        cfg_wdata_i   = '0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [7:0]         opacity_o;
  logic [1:0]         phase_o;
  logic               timer_running_o;

  int fail_count;
  int pending;
  int checked;

  int items_sent    = 0;
  int settings_used = 0;
  int idle_cycles   = 0;

  // receiver stall pattern state
  int rx_left  = 0;
  bit rx_open  = 1'b0;
  int rx_cycle = 0;

  // register values as last written, used only to shape level values
  logic               stim_range_en = RangeEnableRst;
  logic signed [31:0] stim_lo       = RangeLowRst;
  logic signed [31:0] stim_hi       = RangeHighRst;
  logic [15:0]        stim_fade     = FadeMsRst;
  logic [15:0]        stim_hold     = HoldMsRst;

  always #ClkHalf clk_i = ~clk_i;

  trigger_fade_envelope dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .level_value_i  (level_value_i),
    .value_valid_i  (value_valid_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .opacity_o      (opacity_o),
    .phase_o        (phase_o),
    .timer_running_o(timer_running_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  tfe_envelope_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .level_value_i  (level_value_i),
    .value_valid_i  (value_valid_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .opacity_o      (opacity_o),
    .phase_o        (phase_o),
    .timer_running_o(timer_running_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Receiver: alternate open and stalled stretches of random length, short
  // stalls mostly, long ones now and then. Ready stays high throughout while
  // rx_cycle modulo 1024 is 768 or more, so that a stall-free stretch always occurs.
  always @(posedge clk_i) begin
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_open = !rx_open;
      if (rx_open) rx_left = $urandom_range(1, 24);
      else if ($urandom_range(0, 3) == 0) rx_left = $urandom_range(8, 20);
      else rx_left = $urandom_range(0, 3);
    end
    rx_cycle++;
    out_ready_i <= rx_open || (rx_cycle % 1024 >= 768);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, giving up", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it. Valid stays high on
  // return so that a following item goes out back to back.
  task automatic send_item(input logic [1:0] mode, input logic [9:0] dt,
                           input logic [31:0] lvl, input logic ok);
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    elapsed_ms_i  <= dt;
    level_value_i <= lvl;
    value_valid_i <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drive one register write; the caller drops the write enable after the last.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every predicted result has been taken. Read the
  // checker's count on the falling edge, away from its update.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Load one register setting; the block is idle whenever this runs. Narrow
  // registers get junk in the unused upper data bits, which must be ignored.
  task automatic apply_setting(input int k);
    logic [31:0] junk;
    junk = $urandom;
    case (k)
      0: begin  // reversed extremes cover the whole value range; zero-length timing
        stim_range_en = 1'b1;
        stim_lo       = 32'h7FFF_FFFF;
        stim_hi       = 32'h8000_0000;
        stim_fade     = 16'd0;
        stim_hold     = 16'd0;
      end
      1: begin  // every level item flashes; longest timing
        stim_range_en = 1'b0;
        stim_lo       = $urandom;
        stim_hi       = $urandom;
        stim_fade     = 16'hFFFF;
        stim_hold     = 16'hFFFF;
      end
      2: begin  // swapped bounds around zero, short fades
        stim_range_en = 1'b1;
        stim_lo       = 5 * QOne;
        stim_hi       = -5 * QOne;
        stim_fade     = 16'd30;
        stim_hold     = 16'd20;
      end
      3: begin  // single-point range, 1 ms fade, longest hold
        stim_range_en = 1'b1;
        stim_lo       = '0;
        stim_hi       = '0;
        stim_fade     = 16'd1;
        stim_hold     = 16'hFFFF;
      end
      4: begin
        stim_range_en = 1'b1;
        stim_lo       = $urandom_range(0, 200000) - 100000;
        stim_hi       = $urandom_range(0, 200000) - 100000;
        stim_fade     = 16'($urandom_range(0, 300));
        stim_hold     = 16'($urandom_range(0, 300));
      end
      5: begin
        stim_range_en = 1'($urandom_range(0, 1));
        stim_lo       = $urandom;
        stim_hi       = $urandom;
        stim_fade     = 16'($urandom_range(0, 2000));
        stim_hold     = 16'($urandom_range(0, 2000));
      end
      default: begin  // back to the reset values
        stim_range_en = RangeEnableRst;
        stim_lo       = RangeLowRst;
        stim_hi       = RangeHighRst;
        stim_fade     = FadeMsRst;
        stim_hold     = HoldMsRst;
      end
    endcase
    write_reg(CfgRangeEnable, {junk[31:1], stim_range_en});
    write_reg(CfgRangeLow, stim_lo);
    write_reg(CfgRangeHigh, stim_hi);
    write_reg(CfgFadeMs, {junk[31:16], stim_fade});
    write_reg(CfgHoldMs, {junk[15:0], stim_hold});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random traffic under the current setting: bursts of items with gaps in
  // between, one forced drain halfway through, and a drain at the end.
  task automatic run_random(input int count);
    int              sent;
    int              burst;
    int              gap;
    int              pick;
    int unsigned     dt_cap;
    logic [1:0]      mode;
    logic [9:0]      dt;
    logic [31:0]     lvl;
    logic            ok;
    longint          lo;
    longint          hi;
    longint unsigned span;
    longint unsigned off;
    logic [63:0]     wide;
    // scale tick sizes to the timing so every phase gets several ticks
    dt_cap = 32'(((stim_fade > stim_hold) ? stim_fade : stim_hold) / 8);
    if (dt_cap < 4) dt_cap = 4;
    if (dt_cap > 1023) dt_cap = 1023;
    lo = longint'(stim_lo);
    hi = longint'(stim_hi);
    if (lo > hi) begin
      lo = longint'(stim_hi);
      hi = longint'(stim_lo);
    end
    span = hi - lo;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < count; b++) begin
        pick = $urandom_range(0, 99);
        dt   = 10'($urandom_range(0, 1023));
        lvl  = $urandom;
        ok   = 1'($urandom_range(0, 1));
        if (pick < 55) begin
          mode = ModeTick;
          if ($urandom_range(0, 7) != 0) dt = 10'($urandom_range(0, dt_cap));
        end else if (pick < 70) begin
          mode = ModeTrigger;
        end else if (pick < 95) begin
          mode = ModeLevel;
          ok   = ($urandom_range(0, 7) != 0);
          case ($urandom_range(0, 5))
            0, 1: begin  // somewhere in the range
              off  = {$urandom, $urandom} % (span + 1);
              wide = lo + off;
              lvl  = wide[31:0];
            end
            2: lvl = $urandom_range(0, 1) ? lo[31:0] : hi[31:0];
            3: begin  // just past a bound
              wide = $urandom_range(0, 1) ? lo - 1 : hi + 1;
              lvl  = wide[31:0];
            end
            default: ;
          endcase
        end else begin
          mode = ModeUnused;
        end
        send_item(mode, dt, lvl, ok);
        sent++;
        if (sent == count / 2) drain();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with the reset setting: fade 200 ms, no hold,
    // range 66 .. 65536000.
    send_item(ModeUnused, 10'h3FF, 32'hFFFF_FFFF, 1'b1);  // unused mode does nothing
    send_item(ModeTick, 10'd1023, '0, 1'b0);              // timer stopped: no progress
    send_item(ModeTrigger, '0, '0, 1'b0);                 // flash starts the fade in
    send_item(ModeTick, 10'd50, '0, 1'b0);
    send_item(ModeTrigger, '0, '0, 1'b0);                 // re-trigger while fading in
    send_item(ModeTick, 10'd100, '0, 1'b0);
    send_item(ModeLevel, '0, QOne, 1'b1);                 // inside range: infinite hold
    send_item(ModeTick, 10'd60, '0, 1'b0);                // fade done, on
    send_item(ModeTick, 10'd0, '0, 1'b0);                 // infinite hold stops timer
    send_item(ModeTick, 10'd500, '0, 1'b0);
    send_item(ModeTrigger, '0, '0, 1'b0);                 // new timing restarts the timer
    send_item(ModeTick, 10'd80, '0, 1'b0);                // partway through fade out
    send_item(ModeLevel, '0, 32'd66, 1'b1);               // low bound: reverse to fade in
    send_item(ModeLevel, '0, 32'd65536000, 1'b1);         // high bound
    send_item(ModeLevel, '0, QOne, 1'b0);                 // unreadable value counts as out
    send_item(ModeLevel, '0, 32'd65, 1'b1);               // just below the range
    send_item(ModeLevel, '0, 32'h7FFF_FFFF, 1'b1);
    send_item(ModeLevel, '0, 32'h8000_0000, 1'b1);
    send_item(ModeTick, 10'd1023, '0, 1'b0);              // fade out finishes, off
    send_item(ModeLevel, '0, 32'd65536001, 1'b1);         // just above, already off
    send_item(ModeUnused, '0, '0, 1'b0);
    send_item(ModeTick, 10'd0, '0, 1'b0);
    drain();

    for (int k = 0; k < Phases; k++) begin
      apply_setting(k);
      run_random(PhaseItems);
    end

    // nothing should arrive after the queue empties
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d items (directed walk plus random bursts) under %0d register settings;",
             items_sent, settings_used + 1);
    $display("compared %0d results on opacity, phase and timer state.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
